// File: hw/rtl/htq_pkg.sv
package htq_pkg;

   // field and counter widths of the histogram
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 32;
   localparam int WIDTH_W = 31;
   localparam int FRAC_W  = 17;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MIN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MAX    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_WIDTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTILE     = 2'd3;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0] count_type;

endpackage

// File: hw/rtl/histogram_tree_quantile_core.sv
// per request: each value gets a bucket division (skipped below range_min) and a tree
// read-modify-write down to its bucket, then the quantile walk runs, plus selection, rank,
// bucket middle and hand-off steps; an empty histogram skips the walk
// one item at a time; the next request waits until the result is handed off past rsp_stall
// reset: synchronous; a clearing pass zeroes all 4*BUCKETS memory words, req_stall stays high
module histogram_tree_quantile_core #(
   parameter int BUCKETS = 512
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_remove_valid,
   input  htq_pkg::value_type                       req_remove_value,
   input  logic                                     req_add_valid,
   input  htq_pkg::value_type                       req_add_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output htq_pkg::value_type                       rsp_quantile_value,
   input  logic                                     csr_we,
   input  logic [htq_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [htq_pkg::VALUE_W-1:0]              csr_wdata
);
   import htq_pkg::*;

   localparam int TREE_NODES = 4 * BUCKETS;
   localparam int NW = $clog2(TREE_NODES);
   localparam int BW = $clog2(BUCKETS + 1);
   localparam int NEED_W = 40;
   localparam int MID_W = 50;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_SEL      = 4'd2;
   localparam logic [3:0] S_DIV      = 4'd3;
   localparam logic [3:0] S_UPD_RD   = 4'd4;
   localparam logic [3:0] S_UPD_WR   = 4'd5;
   localparam logic [3:0] S_TOTAL    = 4'd6;
   localparam logic [3:0] S_NEED     = 4'd7;
   localparam logic [3:0] S_FIND_RD  = 4'd8;
   localparam logic [3:0] S_FIND_CMP = 4'd9;
   localparam logic [3:0] S_MID_MUL  = 4'd10;
   localparam logic [3:0] S_MID_ADD  = 4'd11;
   localparam logic [3:0] S_DONE     = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [NW-1:0] clr_ff, clr_in;
   value_type rmin_ff, rmin_in, rmax_ff, rmax_in;
   logic [WIDTH_W-1:0] bw_ff, bw_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   count_type total_ff, total_in;
   logic rm_pend_ff, rm_pend_in, add_pend_ff, add_pend_in;
   value_type rm_val_ff, rm_val_in, add_val_ff, add_val_in;
   logic dec_ff, dec_in;
   logic [31:0] dvd_ff, dvd_in, rem_ff, rem_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [BW-1:0] bucket_ff, bucket_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [NW-1:0] node_ff, node_in;
   logic signed [NEED_W-1:0] need_ff, need_in;
   logic [47:0] prod_ff, prod_in;
   value_type res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   value_type rsp_data_ff, rsp_data_in;

   // count memory
   logic [COUNT_W-1:0] mem [TREE_NODES];
   logic [COUNT_W-1:0] rd_data_ff;
   logic [NW-1:0] rd_addr, wr_addr;
   logic [COUNT_W-1:0] wr_data;
   logic wr_en;

   // combinational helpers
   logic [WIDTH_W-1:0] w_eff;
   logic [BW:0] lo_hi_sum;
   logic [BW-1:0] mid;
   logic span_gt1;
   logic signed [32:0] diff;
   logic [32:0] rem_sh;
   logic div_ge;
   logic [31:0] quot;
   logic signed [NEED_W-1:0] left_cnt;
   logic [31:0] need_raw;
   logic signed [MID_W-1:0] mid_sum;
   value_type sel_val;

   assign w_eff     = (bw_ff == '0) ? WIDTH_W'(1) : bw_ff;
   assign lo_hi_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = lo_hi_sum[BW:1];
   assign span_gt1  = (hi_ff - lo_ff) > BW'(1);
   assign sel_val   = rm_pend_ff ? rm_val_ff : add_val_ff;
   assign diff      = {sel_val[31], sel_val} - {rmin_ff[31], rmin_ff};
   assign rem_sh    = {rem_ff, dvd_ff[31]};
   assign div_ge    = rem_sh >= {2'b00, w_eff};
   assign quot      = {dvd_ff[30:0], div_ge};
   assign left_cnt  = NEED_W'($signed(rd_data_ff));
   assign need_raw  = prod_ff[47:16];
   assign mid_sum   = MID_W'(rmin_ff) + $signed({2'b00, prod_ff})
                      + $signed(MID_W'({w_eff >> 1}));

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quantile_value = rsp_data_ff;

   // memory with one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rmin_in      = rmin_ff;
      rmax_in      = rmax_ff;
      bw_in        = bw_ff;
      frac_in      = frac_ff;
      total_in     = total_ff;
      rm_pend_in   = rm_pend_ff;
      add_pend_in  = add_pend_ff;
      rm_val_in    = rm_val_ff;
      add_val_in   = add_val_ff;
      dec_in       = dec_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      bucket_in    = bucket_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      node_in      = node_ff;
      need_in      = need_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = node_ff;
      wr_addr      = node_ff;
      wr_data      = rd_data_ff + (dec_ff ? '1 : COUNT_W'(1));
      wr_en        = 1'b0;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_RANGE_MIN:    rmin_in = csr_wdata;
            CSR_RANGE_MAX:    rmax_in = csr_wdata;
            CSR_BUCKET_WIDTH: bw_in   = csr_wdata[WIDTH_W-1:0];
            CSR_QUANTILE:     frac_in = csr_wdata[FRAC_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + NW'(1);
            if (clr_ff == NW'(TREE_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               rm_pend_in  = req_remove_valid;
               add_pend_in = req_add_valid;
               rm_val_in   = req_remove_value;
               add_val_in  = req_add_value;
               state_in    = S_SEL;
            end
         end
         // pick the next value: removal before addition
         S_SEL: begin
            if (rm_pend_ff || add_pend_ff) begin
               dec_in      = rm_pend_ff;
               rm_pend_in  = 1'b0;
               add_pend_in = rm_pend_ff ? add_pend_ff : 1'b0;
               node_in     = '0;
               lo_in       = '0;
               hi_in       = BW'(BUCKETS);
               if (diff < 0) begin
                  bucket_in = '0;
                  state_in  = S_UPD_RD;
               end else begin
                  dvd_in   = diff[31:0];
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = S_DIV;
               end
            end else begin
               state_in = S_TOTAL;
            end
         end
         // restoring division, one quotient bit per cycle
         S_DIV: begin
            rem_in = div_ge ? 32'(rem_sh - {2'b00, w_eff}) : rem_sh[31:0];
            dvd_in = quot;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               bucket_in = (quot > 32'(BUCKETS - 1)) ? BW'(BUCKETS - 1) : quot[BW-1:0];
               state_in  = S_UPD_RD;
            end
         end
         S_UPD_RD: begin
            rd_addr  = node_ff;
            state_in = S_UPD_WR;
         end
         // write back the adjusted count and descend toward the bucket
         S_UPD_WR: begin
            wr_en = 1'b1;
            if (span_gt1) begin
               if (bucket_ff < mid) begin
                  node_in = NW'({node_ff, 1'b1});
                  hi_in   = mid;
               end else begin
                  node_in = NW'({node_ff, 1'b0} + (NW + 1)'(2));
                  lo_in   = mid;
               end
               state_in = S_UPD_RD;
            end else begin
               total_in = total_ff + (dec_ff ? '1 : COUNT_W'(1));
               state_in = S_SEL;
            end
         end
         S_TOTAL: begin
            if (total_ff == '0) begin
               res_in   = '0;
               state_in = S_DONE;
            end else begin
               prod_in  = 48'(total_ff[30:0]) * 48'(frac_ff);
               state_in = S_NEED;
            end
         end
         // rank of the wanted count, at least one
         S_NEED: begin
            if (total_ff[31] || (need_raw == '0)) begin
               need_in = NEED_W'(1);
            end else begin
               need_in = $signed(NEED_W'(need_raw));
            end
            node_in  = '0;
            lo_in    = '0;
            hi_in    = BW'(BUCKETS);
            state_in = S_FIND_RD;
         end
         S_FIND_RD: begin
            rd_addr = NW'({node_ff, 1'b1});
            if (span_gt1) begin
               state_in = S_FIND_CMP;
            end else begin
               state_in = S_MID_MUL;
            end
         end
         // compare the left subtree count with the remaining rank
         S_FIND_CMP: begin
            if (left_cnt >= need_ff) begin
               node_in = NW'({node_ff, 1'b1});
               hi_in   = mid;
            end else begin
               node_in = NW'({node_ff, 1'b0} + (NW + 1)'(2));
               lo_in   = mid;
               need_in = need_ff - left_cnt;
            end
            state_in = S_FIND_RD;
         end
         S_MID_MUL: begin
            prod_in  = 48'(lo_ff) * 48'(w_eff);
            state_in = S_MID_ADD;
         end
         S_MID_ADD: begin
            if (mid_sum > MID_W'(rmax_ff)) begin
               res_in = rmax_ff;
            end else begin
               res_in = mid_sum[31:0];
            end
            state_in = S_DONE;
         end
         // hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rmin_ff      <= '0;
         rmax_ff      <= 32'sd500;
         bw_ff        <= WIDTH_W'(1);
         frac_ff      <= FRAC_W'(65536);
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rm_pend_ff   <= 1'b0;
         add_pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rmin_ff      <= rmin_in;
         rmax_ff      <= rmax_in;
         bw_ff        <= bw_in;
         frac_ff      <= frac_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         rm_pend_ff   <= rm_pend_in;
         add_pend_ff  <= add_pend_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rm_val_ff   <= rm_val_in;
      add_val_ff  <= add_val_in;
      dec_ff      <= dec_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      bucket_ff   <= bucket_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      node_ff     <= node_in;
      need_ff     <= need_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // no new response is produced while the clearing pass runs
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |=> !$rose(rsp_valid))
      else $error("response during clearing pass");

   // memory writes only come from clearing or tree update
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CLEAR || state_ff == S_UPD_WR))
      else $error("unexpected count memory write");

   // the remaining rank stays positive during the quantile walk
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND_RD || state_ff == S_FIND_CMP) |-> need_ff > 0)
      else $error("quantile rank not positive");

   // the walked range never collapses
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD_WR || state_ff == S_FIND_CMP) |-> hi_ff > lo_ff)
      else $error("empty bucket range in walk");

   // a new result only enters the output register from the final state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_DONE)
      else $error("response without finished item");

endmodule

// File: tb/tb_histogram_tree_quantile_core.sv
`timescale 1ns / 1ps

module tb_histogram_tree_quantile_core;
   import htq_pkg::*;

   localparam int  NUM_BUCKETS  = 512;
   localparam int  NUM_NODES    = 4 * NUM_BUCKETS;
   localparam int  ITEMS_PER_PHASE = 130;
   localparam int  NUM_PHASES   = 8;
   localparam longint CYCLE_LIMIT = 1500000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_remove_valid = 1'b0;
   value_type         req_remove_value = '0;
   logic              req_add_valid = 1'b0;
   value_type         req_add_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   value_type         rsp_quantile_value;
   logic              csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [VALUE_W-1:0]   csr_wdata = '0;

   histogram_tree_quantile_core #(.BUCKETS(NUM_BUCKETS)) DUT (.*);

   always #10 clock = ~clock;

   // histogram shadow state and register copies
   count_type hist_tree [NUM_NODES];
   count_type hist_total;
   longint    cfg_min, cfg_max, cfg_width, cfg_frac;
   logic [31:0] quantile_expect [$];
   logic [31:0] live_values [$];

   int  error_count = 0;
   int  items_sent = 0;
   int  results_checked = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   longint cycle_count = 0;

   typedef struct {
      bit          rv;
      logic [31:0] rval;
      bit          av;
      logic [31:0] aval;
      bit          known;
      logic [31:0] result;
   } directed_row_type;

   directed_row_type directed_rows [13];

   function automatic longint width_eff();
      return (cfg_width == 0) ? 1 : cfg_width;
   endfunction

   function automatic longint bucket_index(logic [31:0] v);
      longint d, b;
      d = longint'($signed(v)) - cfg_min;
      if (d < 0) return 0;
      b = d / width_eff();
      if (b > NUM_BUCKETS - 1) b = NUM_BUCKETS - 1;
      return b;
   endfunction

   // bump every node on the path down to the bucket
   function automatic void tree_update(longint bucket, count_type delta);
      longint node, lo, hi, mid;
      node = 0; lo = 0; hi = NUM_BUCKETS;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         hist_tree[node] += delta;
         if (bucket < mid) begin
            node = 2 * node + 1;
            hi = mid;
         end else begin
            node = 2 * node + 2;
            lo = mid;
         end
      end
      hist_tree[node] += delta;
   endfunction

   // rank walk from the root, counts read as signed
   function automatic longint rank_bucket(longint need);
      longint node, lo, hi, mid, left;
      node = 0; lo = 0; hi = NUM_BUCKETS;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         left = longint'($signed(hist_tree[2 * node + 1]));
         if (left >= need) begin
            node = 2 * node + 1;
            hi = mid;
         end else begin
            node = 2 * node + 2;
            lo = mid;
            need -= left;
         end
      end
      return lo;
   endfunction

   function automatic logic [31:0] step_histogram(bit rv, logic [31:0] rval,
                                                   bit av, logic [31:0] aval);
      longint tot, need, b, w, mid;
      if (rv) begin
         tree_update(bucket_index(rval), 32'hFFFF_FFFF);
         hist_total -= 1;
      end
      if (av) begin
         tree_update(bucket_index(aval), 32'd1);
         hist_total += 1;
      end
      tot = longint'($signed(hist_total));
      if (tot == 0) return 32'd0;
      if (tot < 0) need = 1;
      else begin
         need = (tot * cfg_frac) >>> 16;
         if (need < 1) need = 1;
      end
      b = rank_bucket(need);
      w = width_eff();
      mid = cfg_min + b * w + w / 2;
      if (mid > cfg_max) mid = cfg_max;
      return mid[31:0];
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_histogram_tree_quantile_core failed");
         $finish;
      end
   end

   // receiver backpressure
   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (quantile_expect.size() == 0) begin
            $error("quantile_value: unexpected result %0d", rsp_quantile_value);
            error_count++;
         end else begin
            logic [31:0] want;
            want = quantile_expect.pop_front();
            results_checked++;
            if (rsp_quantile_value !== want) begin
               $error("quantile_value mismatch: expected %0d, got %0d",
                      $signed(want), rsp_quantile_value);
               error_count++;
            end
         end
      end
   end

   // one transfer on the request channel, random idle gaps before it
   task automatic send_item(bit rv, logic [31:0] rval, bit av, logic [31:0] aval,
                            bit known, logic [31:0] result);
      logic [31:0] predicted;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_remove_valid <= rv;
      req_remove_value <= rval;
      req_add_valid    <= av;
      req_add_value    <= aval;
      do @(posedge clock); while (req_stall);
      predicted = step_histogram(rv, rval, av, aval);
      quantile_expect.push_back(known ? result : predicted);
      items_sent++;
   endtask

   // registers are written back to back, enable dropped after the last one
   task automatic apply_config(longint rmin, longint rmax, longint w, longint q);
      logic [31:0] vals [4];
      logic [CSR_IDX_W-1:0] idx [4];
      vals = '{rmin[31:0], rmax[31:0], w[31:0], q[31:0]};
      idx  = '{CSR_RANGE_MIN, CSR_RANGE_MAX, CSR_BUCKET_WIDTH, CSR_QUANTILE};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg_min   = longint'($signed(vals[0]));
      cfg_max   = longint'($signed(vals[1]));
      cfg_width = longint'(vals[2] & 32'h7FFF_FFFF);
      cfg_frac  = longint'(vals[3] & 32'h1_FFFF);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (quantile_expect.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // value near the tracked range, sometimes just below or above it
   function automatic logic [31:0] near_value();
      longint v, w;
      w = width_eff();
      v = cfg_min + longint'($urandom_range(0, NUM_BUCKETS + 8)) * w
          + longint'($urandom_range(0, w - 1)) - longint'($urandom_range(0, 3));
      return v[31:0];
   endfunction

   task automatic random_item();
      int kind;
      bit rv, av;
      logic [31:0] rval, aval;
      int k;
      kind = $urandom_range(0, 99);
      rv = 0; av = 0; rval = $urandom; aval = $urandom;
      if (kind < 75) begin
         // well-formed: add a value near the range, sometimes retire an earlier value
         av = 1;
         aval = near_value();
         if (live_values.size() > 0 && (live_values.size() > 40 || $urandom_range(0, 1))) begin
            k = $urandom_range(0, live_values.size() - 1);
            rv = 1;
            rval = live_values[k];
            live_values.delete(k);
         end
         live_values.push_back(aval);
      end else if (kind < 90) begin
         // removal of values never added, full-width adds
         rv = 1'($urandom_range(0, 1));
         av = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 1)) rval = near_value();
      end else begin
         av = 1'($urandom_range(0, 1));
         if (av && $urandom_range(0, 1)) begin
            aval = near_value();
            live_values.push_back(aval);
         end
      end
      send_item(rv, rval, av, aval, 1'b0, 32'd0);
   endtask

   initial begin
      longint cfg_rows [NUM_PHASES][4];
      cfg_rows = '{
         '{0, 500, 1, 65536},
         '{-1000, 1000, 4, 32768},
         '{-64'sd2147483648, 2147483647, 2147483647, 0},
         '{100, 50, 0, 131071},
         '{2147483647, -64'sd2147483648, 1, 1},
         '{-5000, 20000, 49, 49152},
         '{0, 500, 3, 65535},
         '{-300, 300, 2, 16384}};

      // empty, extremes, clamps, both ops, removal from empty
      directed_rows = '{
         '{0, 32'h0, 0, 32'h0, 1, 32'd0},
         '{0, 32'h0, 1, 32'h0, 1, 32'd0},
         '{0, 32'h0, 1, 32'd500, 1, 32'd500},
         '{0, 32'h0, 1, 32'h7FFF_FFFF, 1, 32'd500},
         '{0, 32'h0, 1, 32'h8000_0000, 1, 32'd500},
         '{1, 32'h7FFF_FFFF, 0, 32'h0, 1, 32'd500},
         '{1, 32'h8000_0000, 1, 32'd5, 0, 32'd0},
         '{1, 32'h0, 0, 32'h0, 0, 32'd0},
         '{1, 32'd500, 0, 32'h0, 0, 32'd0},
         '{1, 32'd5, 0, 32'h0, 1, 32'd0},
         '{1, 32'd123, 0, 32'h0, 0, 32'd0},
         '{0, 32'h0, 1, 32'd123, 1, 32'd0},
         '{1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 32'd0}};

      foreach (hist_tree[i]) hist_tree[i] = '0;
      hist_total = '0;
      cfg_min = 0; cfg_max = 500; cfg_width = 1; cfg_frac = 65536;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      apply_config(0, 500, 1, 65536);
      foreach (directed_rows[i])
         send_item(directed_rows[i].rv, directed_rows[i].rval, directed_rows[i].av,
                   directed_rows[i].aval, directed_rows[i].known, directed_rows[i].result);
      drain();

      // random phases, each with its own settings and one of four idling patterns
      for (int p = 0; p < NUM_PHASES; p++) begin
         apply_config(cfg_rows[p][0], cfg_rows[p][1], cfg_rows[p][2], cfg_rows[p][3]);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 46; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 46; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item();
         drain();
      end

      $display("run covered %0d request transfers and %0d checked results over %0d settings",
               items_sent, results_checked, NUM_PHASES + 1);
      if (error_count == 0)
         $display("tb_histogram_tree_quantile_core passed");
      else
         $display("tb_histogram_tree_quantile_core failed");
      $finish;
   end

endmodule
